FILE: design/euler_relative_quaternion_rotate_core_defines.svh
// assertion macros used by the checker file
`ifndef EULER_RELATIVE_QUATERNION_ROTATE_CORE_DEFINES_SVH
`define EULER_RELATIVE_QUATERNION_ROTATE_CORE_DEFINES_SVH

// concurrent check, off while reset is asserted
`define ERQ_ASSERT_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("erq check failed");

// concurrent check that also holds across reset
`define ERQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("erq reset check failed");

`endif

FILE: design/erq_pkg.sv
// shared types and constants of the quaternion rotate core
`default_nettype none
package erq_pkg;

    // angle input format
    localparam int ANGLE_FRAC_BITS = 6;

    // lanes of the angle datapath
    localparam int NUM_ANGLES = 3;
    localparam int ROLL  = 0;
    localparam int PITCH = 1;
    localparam int YAW   = 2;

    // half-angle phase: den = 720 * 2^frac = 45 * 2^PH_SHIFT
    localparam int         PH_SHIFT = 4 + ANGLE_FRAC_BITS;
    localparam logic [63:0] PH_DEN  = 64'd45 << PH_SHIFT;
    localparam logic [63:0] PH_QUOT = (64'd1 << 32) / PH_DEN;
    localparam logic [5:0]  PH_REM  = 6'(((64'd1 << (32 - PH_SHIFT)) % 64'd45));
    localparam logic [5:0]  PH_HALF = 6'd22;
    localparam logic [63:0] RECIP45 = ((64'd1 << 32) + 64'd44) / 64'd45;
    localparam int          PH_Y_W  = 23;
    localparam int          PHASE_LAT = 2;

    // cordic
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;

    localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
        32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
        32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
        32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
        32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
    };

    // quadrant held in the top two phase bits
    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    // q1.30 cosine or sine
    typedef logic signed [31:0] t_trig;
    typedef logic signed [15:0] t_angle;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } t_quat;

    localparam int QMUL_LAT = 5;
    localparam int QUAT_DLY = PHASE_LAT + CORDIC_LAT;

endpackage
`default_nettype wire

FILE: design/erq_if.sv
// handshake channels of the quaternion rotate core
`default_nettype none
interface erq_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cur_qx;
    logic signed [15:0] cur_qy;
    logic signed [15:0] cur_qz;
    logic signed [15:0] cur_qw;
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;

    modport source (
        output valid, cur_qx, cur_qy, cur_qz, cur_qw, roll_deg, pitch_deg, yaw_deg,
        input  ready
    );
    modport sink (
        input  valid, cur_qx, cur_qy, cur_qz, cur_qw, roll_deg, pitch_deg, yaw_deg,
        output ready
    );
endinterface

interface erq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] new_qx;
    logic signed [15:0] new_qy;
    logic signed [15:0] new_qz;
    logic signed [15:0] new_qw;

    modport source (
        output valid, new_qx, new_qy, new_qz, new_qw,
        input  ready
    );
    modport sink (
        input  valid, new_qx, new_qy, new_qz, new_qw,
        output ready
    );
endinterface
`default_nettype wire

FILE: design/erq_phase.sv
// angle to half-angle phase, two register stages
`default_nettype none
module erq_phase (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  erq_pkg::t_angle      i_angle [erq_pkg::NUM_ANGLES],
    output logic                 o_valid,
    output logic [31:0]          o_phase [erq_pkg::NUM_ANGLES]
);
    localparam int NA = erq_pkg::NUM_ANGLES;
    localparam int YW = erq_pkg::PH_Y_W;

    logic            r_v1;
    logic            r_v2;
    logic            r_neg  [NA];
    logic [31:0]     r_mq   [NA];
    logic [YW-1:0]   r_y    [NA];
    logic [31:0]     r_ph   [NA];
    logic            n_neg  [NA];
    logic [31:0]     n_mq   [NA];
    logic [YW-1:0]   n_y    [NA];
    logic [31:0]     n_ph   [NA];

    // stage 1: magnitude times quotient, remainder numerator
    always_comb begin
        logic [15:0] mag;
        for (int l = 0; l < NA; l++) begin
            mag      = i_angle[l][15] ? 16'(-i_angle[l]) : 16'(i_angle[l]);
            n_neg[l] = i_angle[l][15];
            n_mq[l]  = 32'(64'(mag) * erq_pkg::PH_QUOT);
            n_y[l]   = YW'(mag) * YW'(erq_pkg::PH_REM) + YW'(erq_pkg::PH_HALF);
        end
    end

    // stage 2: divide remainder by 45 via reciprocal, add, apply sign
    always_comb begin
        logic [31:0] q;
        logic [31:0] p;
        for (int l = 0; l < NA; l++) begin
            q       = 32'((64'(r_y[l]) * erq_pkg::RECIP45) >> 32);
            p       = r_mq[l] + q;
            n_ph[l] = r_neg[l] ? 32'(0 - p) : p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= n_neg;
            r_mq  <= n_mq;
            r_y   <= n_y;
            r_ph  <= n_ph;
        end
    end

    assign o_valid = r_v2;
    assign o_phase = r_ph;
endmodule
`default_nettype wire

FILE: design/erq_cordic.sv
// pipelined rotation cordic, one step per stage, three lanes
`default_nettype none
module erq_cordic (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [31:0]      i_phase [erq_pkg::NUM_ANGLES],
    output logic             o_valid,
    output erq_pkg::t_trig   o_cos   [erq_pkg::NUM_ANGLES],
    output erq_pkg::t_trig   o_sin   [erq_pkg::NUM_ANGLES]
);
    localparam int NA = erq_pkg::NUM_ANGLES;
    localparam int NS = erq_pkg::CORDIC_STEPS;
    localparam int CW = erq_pkg::CORDIC_W;

    logic signed [CW-1:0] r_x    [NS][NA];
    logic signed [CW-1:0] r_y    [NS][NA];
    logic signed [31:0]   r_z    [NS][NA];
    logic [1:0]           r_quad [NS][NA];
    logic signed [CW-1:0] n_x    [NS][NA];
    logic signed [CW-1:0] n_y    [NS][NA];
    logic signed [31:0]   n_z    [NS][NA];
    logic [1:0]           n_quad [NS][NA];
    logic [NS-1:0]        r_v;
    logic                 r_vo;
    erq_pkg::t_trig       r_cos  [NA];
    erq_pkg::t_trig       r_sin  [NA];
    erq_pkg::t_trig       n_cos  [NA];
    erq_pkg::t_trig       n_sin  [NA];

    // one micro-rotation per stage, each fed by the stage before
    always_comb begin
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [31:0]   cz;
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < NA; l++) begin
                if (k == 0) begin
                    cx           = erq_pkg::CORDIC_INV_GAIN;
                    cy           = '0;
                    cz           = $signed({2'b00, i_phase[l][29:0]});
                    n_quad[k][l] = i_phase[l][31:30];
                end else begin
                    cx           = r_x[k-1][l];
                    cy           = r_y[k-1][l];
                    cz           = r_z[k-1][l];
                    n_quad[k][l] = r_quad[k-1][l];
                end
                if (!cz[31]) begin
                    n_x[k][l] = cx - (cy >>> k);
                    n_y[k][l] = cy + (cx >>> k);
                    n_z[k][l] = cz - erq_pkg::ATAN_TURN[k];
                end else begin
                    n_x[k][l] = cx + (cy >>> k);
                    n_y[k][l] = cy - (cx >>> k);
                    n_z[k][l] = cz + erq_pkg::ATAN_TURN[k];
                end
            end
        end
    end

    // quadrant fold-back after the last step
    always_comb begin
        logic signed [CW-1:0] fx;
        logic signed [CW-1:0] fy;
        for (int l = 0; l < NA; l++) begin
            fx = r_x[NS-1][l];
            fy = r_y[NS-1][l];
            case (erq_pkg::t_quad'(r_quad[NS-1][l]))
                erq_pkg::QUAD_I: begin
                    n_cos[l] = 32'(fx);
                    n_sin[l] = 32'(fy);
                end
                erq_pkg::QUAD_II: begin
                    n_cos[l] = 32'(-fy);
                    n_sin[l] = 32'(fx);
                end
                erq_pkg::QUAD_III: begin
                    n_cos[l] = 32'(-fx);
                    n_sin[l] = 32'(-fy);
                end
                default: begin
                    n_cos[l] = 32'(fy);
                    n_sin[l] = 32'(-fx);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_vo <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_quad <= n_quad;
            r_cos  <= n_cos;
            r_sin  <= n_sin;
        end
    end

    assign o_valid = r_vo;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
endmodule
`default_nettype wire

FILE: design/erq_qmul.sv
// relative quaternion build and hamilton product, five stages
`default_nettype none
module erq_qmul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  erq_pkg::t_trig   i_cos [erq_pkg::NUM_ANGLES],
    input  erq_pkg::t_trig   i_sin [erq_pkg::NUM_ANGLES],
    input  erq_pkg::t_quat   i_quat,
    output logic             o_valid,
    output erq_pkg::t_quat   o_quat
);
    localparam int R = erq_pkg::ROLL;
    localparam int P = erq_pkg::PITCH;
    localparam int Y = erq_pkg::YAW;

    // q30 multiply with round to nearest
    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b;
        return 34'((p + 68'sd536870912) >>> 30);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
        if (v > 23'sd32767)
            return 16'sh7fff;
        else if (v < -23'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    logic [erq_pkg::QMUL_LAT-1:0] r_v;

    // stage 1 regs
    logic signed [33:0] r_cc, r_ss, r_sc, r_cs;
    erq_pkg::t_trig     r_cy, r_sy;
    erq_pkg::t_quat     r_a1;
    // stage 2 regs
    logic signed [33:0] r_sc_cy, r_cs_sy, r_cs_cy, r_sc_sy;
    logic signed [33:0] r_cc_sy, r_ss_cy, r_cc_cy, r_ss_sy;
    erq_pkg::t_quat     r_a2;
    // stage 3 regs
    logic signed [34:0] r_bx, r_by, r_bz, r_bw;
    erq_pkg::t_quat     r_a3;
    // stage 4 regs: A_i * B_j
    logic signed [50:0] r_pr [4][4];
    // stage 5 output
    erq_pkg::t_quat     r_out;
    logic signed [50:0] n_pr [4][4];
    erq_pkg::t_quat     n_out;

    // stage 4 products, rows and columns in x, y, z, w order
    always_comb begin
        logic signed [34:0] b [4];
        logic signed [15:0] a [4];
        a = '{r_a3.x, r_a3.y, r_a3.z, r_a3.w};
        b = '{r_bx, r_by, r_bz, r_bw};
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_pr[i][j] = 51'(a[i]) * 51'(b[j]);
            end
        end
    end

    // stage 5 sums, rounding and saturation
    always_comb begin
        logic signed [52:0] sx, sy, sz, sw;
        sx = 53'(r_pr[3][0]) + 53'(r_pr[0][3]) + 53'(r_pr[1][2]) - 53'(r_pr[2][1]);
        sy = 53'(r_pr[3][1]) - 53'(r_pr[0][2]) + 53'(r_pr[1][3]) + 53'(r_pr[2][0]);
        sz = 53'(r_pr[3][2]) + 53'(r_pr[0][1]) - 53'(r_pr[1][0]) + 53'(r_pr[2][3]);
        sw = 53'(r_pr[3][3]) - 53'(r_pr[0][0]) - 53'(r_pr[1][1]) - 53'(r_pr[2][2]);
        n_out.x = sat16(23'((sx + 53'sd536870912) >>> 30));
        n_out.y = sat16(23'((sy + 53'sd536870912) >>> 30));
        n_out.z = sat16(23'((sz + 53'sd536870912) >>> 30));
        n_out.w = sat16(23'((sw + 53'sd536870912) >>> 30));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[erq_pkg::QMUL_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // roll and pitch pair products
            r_cc <= mulq(34'(i_cos[R]), 34'(i_cos[P]));
            r_ss <= mulq(34'(i_sin[R]), 34'(i_sin[P]));
            r_sc <= mulq(34'(i_sin[R]), 34'(i_cos[P]));
            r_cs <= mulq(34'(i_cos[R]), 34'(i_sin[P]));
            r_cy <= i_cos[Y];
            r_sy <= i_sin[Y];
            r_a1 <= i_quat;
            // times yaw terms
            r_sc_cy <= mulq(r_sc, 34'(r_cy));
            r_cs_sy <= mulq(r_cs, 34'(r_sy));
            r_cs_cy <= mulq(r_cs, 34'(r_cy));
            r_sc_sy <= mulq(r_sc, 34'(r_sy));
            r_cc_sy <= mulq(r_cc, 34'(r_sy));
            r_ss_cy <= mulq(r_ss, 34'(r_cy));
            r_cc_cy <= mulq(r_cc, 34'(r_cy));
            r_ss_sy <= mulq(r_ss, 34'(r_sy));
            r_a2    <= r_a1;
            // relative quaternion
            r_bx <= 35'(r_sc_cy) - 35'(r_cs_sy);
            r_by <= 35'(r_cs_cy) + 35'(r_sc_sy);
            r_bz <= 35'(r_cc_sy) - 35'(r_ss_cy);
            r_bw <= 35'(r_cc_cy) + 35'(r_ss_sy);
            r_a3 <= r_a2;
            r_pr  <= n_pr;
            r_out <= n_out;
        end
    end

    assign o_valid = r_v[erq_pkg::QMUL_LAT-1];
    assign o_quat  = r_out;
endmodule
`default_nettype wire

FILE: design/euler_relative_quaternion_rotate_core.sv
// throughput: one item per cycle unless the output stalls; phase (2), cordic (31) and product (5) stages
// the whole pipeline advances together and halts only while a result waits
// reset: synchronous active low, clears all valid bits; data registers are not reset
`default_nettype none
module euler_relative_quaternion_rotate_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    erq_in_if.sink      i_in,
    erq_out_if.source   o_out
);
    localparam int NA = erq_pkg::NUM_ANGLES;
    localparam int QD = erq_pkg::QUAT_DLY;

    logic                w_en;
    logic                w_ph_valid;
    logic                w_cs_valid;
    logic                w_out_valid;
    erq_pkg::t_angle     w_angle [NA];
    logic [31:0]         w_phase [NA];
    erq_pkg::t_trig      w_cos   [NA];
    erq_pkg::t_trig      w_sin   [NA];
    erq_pkg::t_quat      w_quat_in;
    erq_pkg::t_quat      w_new;
    erq_pkg::t_quat      r_qdly  [QD];

    // pipeline moves whenever the output register is free or drained
    assign w_en       = !w_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    assign w_angle[erq_pkg::ROLL]  = i_in.roll_deg;
    assign w_angle[erq_pkg::PITCH] = i_in.pitch_deg;
    assign w_angle[erq_pkg::YAW]   = i_in.yaw_deg;
    assign w_quat_in = '{x: i_in.cur_qx, y: i_in.cur_qy, z: i_in.cur_qz, w: i_in.cur_qw};

    // current quaternion follows the angle path
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qdly[0] <= w_quat_in;
            for (int k = 1; k < QD; k++) begin
                r_qdly[k] <= r_qdly[k-1];
            end
        end
    end

    erq_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_angle (w_angle),
        .o_valid (w_ph_valid),
        .o_phase (w_phase)
    );

    erq_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ph_valid),
        .i_phase (w_phase),
        .o_valid (w_cs_valid),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    erq_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cs_valid),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .i_quat  (r_qdly[QD-1]),
        .o_valid (w_out_valid),
        .o_quat  (w_new)
    );

    assign o_out.valid  = w_out_valid;
    assign o_out.new_qx = w_new.x;
    assign o_out.new_qy = w_new.y;
    assign o_out.new_qz = w_new.z;
    assign o_out.new_qw = w_new.w;
endmodule
`default_nettype wire

FILE: design/erq_chk.sv
// port-level checks of the quaternion rotate core and their binding
`default_nettype none
`include "euler_relative_quaternion_rotate_core_defines.svh"
module erq_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    // no result right after reset
    `ERQ_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)
    // a stalled result stays offered
    `ERQ_ASSERT_RUN(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    // empty output register never blocks the input
    `ERQ_ASSERT_RUN(a_empty_ready, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)
    // input blocked only by a result that is not taken
    `ERQ_ASSERT_RUN(a_stall_src, i_clk, i_rst_n, !i_in_ready |-> i_out_valid && !i_out_ready)
endmodule

bind euler_relative_quaternion_rotate_core erq_chk u_erq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
`default_nettype wire
